// ===== rtl/core/bbd2x_pkg.sv =====
// ----------------------------------------------------------------------------
// bbd2x_pkg
// Shared constants, the pipeline word type and the frame side decode for the
// binomial blur and 2x downsample unit.
// ----------------------------------------------------------------------------
package bbd2x_pkg;

   localparam int MAX_SIDE  = 1024;
   localparam int HALF_SIDE = MAX_SIDE / 2;
   localparam int PIX_W     = 8;
   localparam int SIDE_W    = 11;
   localparam int CNT_W     = $clog2(MAX_SIDE);
   localparam int ADDR_W    = $clog2(HALF_SIDE);
   localparam int PART_W    = PIX_W + 2;
   localparam int SUM_W     = PIX_W + 3;

   localparam logic [CNT_W-1:0] SIDE_LAST_RESET = CNT_W'(3);

   // One row-blurred word travelling from the front end to the vertical stage.
   typedef struct packed {
      logic [PIX_W-1:0]  h_blur;
      logic [ADDR_W-1:0] col_pair;
      logic              odd_col;
      logic              odd_row;
      logic              top_row;
      logic              frame_last;
   } item_type;

   // Index of the last row and column for a written side length: the low bit
   // is dropped and the result is clamped to the supported range.
   function automatic logic [CNT_W-1:0] side_last(input logic [SIDE_W-1:0] value);
      logic [SIDE_W-1:0] eff;
      eff = {value[SIDE_W-1:1], 1'b0};
      if (eff < SIDE_W'(2)) begin
         eff = SIDE_W'(2);
      end
      if (eff > SIDE_W'(MAX_SIDE)) begin
         eff = SIDE_W'(MAX_SIDE);
      end
      return CNT_W'(eff - SIDE_W'(1));
   endfunction

endpackage

// ===== rtl/core/bbd2x_if.sv =====
// ----------------------------------------------------------------------------
// bbd2x channel interfaces
// Valid/ready channels for pixels in, results out and the side length write.
// ----------------------------------------------------------------------------
interface bbd2x_req_if;
   logic                         valid;
   logic                         ready;
   logic [bbd2x_pkg::PIX_W-1:0]  pixel_in;
   modport source (output valid, output pixel_in, input ready);
   modport sink   (input valid, input pixel_in, output ready);
endinterface

interface bbd2x_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bbd2x_pkg::PIX_W-1:0]  pixel_out;
   logic                         frame_last;
   modport source (output valid, output pixel_out, output frame_last, input ready);
   modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

interface bbd2x_csr_if;
   logic                         valid;
   logic                         ready;
   logic [bbd2x_pkg::SIDE_W-1:0] side_len;
   modport source (output valid, output side_len, input ready);
   modport sink   (input valid, input side_len, output ready);
endinterface

// ===== rtl/core/bbd2x_front.sv =====
// ----------------------------------------------------------------------------
// bbd2x_front
// Frame position counters, horizontal [1 2 1]/4 blur and the first pipeline
// register.
// ----------------------------------------------------------------------------
module bbd2x_front (
   input  logic                     clock,
   input  logic                     reset,
   bbd2x_req_if.sink                req_bus,
   bbd2x_csr_if.sink                csr_bus,
   output logic                     s1_valid,
   output bbd2x_pkg::item_type      s1_item,
   input  logic                     s1_take
);

   logic [bbd2x_pkg::CNT_W-1:0] side_last_ff, side_last_in;
   logic [bbd2x_pkg::CNT_W-1:0] row_ff, row_in;
   logic [bbd2x_pkg::CNT_W-1:0] col_ff, col_in;
   logic [bbd2x_pkg::PIX_W-1:0] prev_ff, prev_in;
   logic [bbd2x_pkg::PIX_W-1:0] prev_prev_ff, prev_prev_in;
   logic                        s1_valid_ff, s1_valid_in;
   bbd2x_pkg::item_type         s1_item_ff, s1_item_in;

   logic                        accept;
   logic                        col_wrap;
   logic                        row_wrap;
   logic [bbd2x_pkg::PART_W-1:0] h_sum;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = !s1_valid_ff || s1_take;
   assign accept        = req_bus.valid && req_bus.ready;

   assign col_wrap = (col_ff == side_last_ff);
   assign row_wrap = (row_ff == side_last_ff);

   // prev_prev_ff is already zero on column one, which gives the left padding.
   assign h_sum = {2'b00, req_bus.pixel_in}
                + {1'b0, prev_ff, 1'b0}
                + {2'b00, prev_prev_ff};

   always_comb begin
      side_last_in = side_last_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      prev_in      = prev_ff;
      prev_prev_in = prev_prev_ff;
      s1_item_in   = s1_item_ff;
      s1_valid_in  = s1_valid_ff && !s1_take;

      if (accept) begin
         s1_valid_in           = 1'b1;
         s1_item_in.h_blur     = h_sum[bbd2x_pkg::PART_W-1:2];
         s1_item_in.col_pair   = col_ff[bbd2x_pkg::CNT_W-1:1];
         s1_item_in.odd_col    = col_ff[0];
         s1_item_in.odd_row    = row_ff[0];
         s1_item_in.top_row    = (row_ff == '0);
         s1_item_in.frame_last = row_wrap && col_wrap;

         prev_prev_in = (col_ff == '0) ? '0 : prev_ff;
         prev_in      = req_bus.pixel_in;
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : row_ff + bbd2x_pkg::CNT_W'(1);
         end else begin
            col_in = col_ff + bbd2x_pkg::CNT_W'(1);
         end
      end

      // A side length write restarts the frame.
      if (csr_bus.valid) begin
         side_last_in = bbd2x_pkg::side_last(csr_bus.side_len);
         row_in       = '0;
         col_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_last_ff <= bbd2x_pkg::SIDE_LAST_RESET;
         row_ff       <= '0;
         col_ff       <= '0;
         prev_ff      <= '0;
         prev_prev_ff <= '0;
         s1_valid_ff  <= 1'b0;
      end else begin
         side_last_ff <= side_last_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         prev_ff      <= prev_in;
         prev_prev_ff <= prev_prev_in;
         s1_valid_ff  <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
   end

   assign s1_valid = s1_valid_ff;
   assign s1_item  = s1_item_ff;

   a_col_in_frame: assert property (@(posedge clock) disable iff (reset)
      col_ff <= side_last_ff && row_ff <= side_last_ff)
      else $error("frame position beyond the last column or row");

   a_col_wraps: assert property (@(posedge clock) disable iff (reset)
      accept && col_wrap |=> col_ff == '0)
      else $error("column counter did not wrap after the last column");

endmodule

// ===== rtl/core/bbd2x_vert.sv =====
// ----------------------------------------------------------------------------
// bbd2x_vert
// Vertical [1 2 1]/4 blur over the row stores, decimation and the result
// register.
// ----------------------------------------------------------------------------
module bbd2x_vert (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     s1_valid,
   input  bbd2x_pkg::item_type      s1_item,
   output logic                     s1_take,
   bbd2x_rsp_if.source              rsp_bus
);

   // Row-blurred previous odd row, and above + 2 * current even row.
   logic [bbd2x_pkg::PIX_W-1:0]  odd_row_mem [bbd2x_pkg::HALF_SIDE];
   logic [bbd2x_pkg::PART_W-1:0] partial_mem [bbd2x_pkg::HALF_SIDE];

   logic                         s2_valid_ff, s2_valid_in;
   bbd2x_pkg::item_type          s2_item_ff;
   logic [bbd2x_pkg::PIX_W-1:0]  above_rd_ff;
   logic [bbd2x_pkg::PART_W-1:0] partial_rd_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [bbd2x_pkg::PIX_W-1:0]  pixel_out_ff;
   logic                         frame_last_ff;

   logic                         s2_result;
   logic                         s2_move;
   logic                         s2_write;
   logic [bbd2x_pkg::PIX_W-1:0]  above;
   logic [bbd2x_pkg::PART_W-1:0] partial_new;
   logic [bbd2x_pkg::SUM_W-1:0]  v_sum;

   assign s2_result = s2_valid_ff && s2_item_ff.odd_col && s2_item_ff.odd_row;
   // Words that give no result leave without waiting for the output side.
   assign s2_move   = !s2_result || !rsp_valid_ff || rsp_bus.ready;
   assign s1_take   = s2_move;
   assign s2_write  = s2_valid_ff && s2_move && s2_item_ff.odd_col;

   assign s2_valid_in  = s2_move ? s1_valid : s2_valid_ff;
   assign rsp_valid_in = (s2_result && s2_move) || (rsp_valid_ff && !rsp_bus.ready);

   assign above       = s2_item_ff.top_row ? '0 : above_rd_ff;
   assign partial_new = {2'b00, above} + {1'b0, s2_item_ff.h_blur, 1'b0};
   assign v_sum       = {1'b0, partial_rd_ff} + {3'b000, s2_item_ff.h_blur};

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The even row writes an entry at least two words before the odd row reads
   // it, so the registered reads never need bypassing.
   always_ff @(posedge clock) begin
      if (s2_move) begin
         s2_item_ff    <= s1_item;
         above_rd_ff   <= odd_row_mem[s1_item.col_pair];
         partial_rd_ff <= partial_mem[s1_item.col_pair];
      end
      if (s2_write && s2_item_ff.odd_row) begin
         odd_row_mem[s2_item_ff.col_pair] <= s2_item_ff.h_blur;
      end
      if (s2_write && !s2_item_ff.odd_row) begin
         partial_mem[s2_item_ff.col_pair] <= partial_new;
      end
      if (s2_result && s2_move) begin
         pixel_out_ff  <= v_sum[bbd2x_pkg::PART_W-1:2];
         frame_last_ff <= s2_item_ff.frame_last;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.pixel_out  = pixel_out_ff;
   assign rsp_bus.frame_last = frame_last_ff;

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s2_result))
      else $error("result word appeared without a decimated pixel behind it");

endmodule

// ===== rtl/core/binomial_blur_downsample_2x_unit.sv =====
// ----------------------------------------------------------------------------
// binomial_blur_downsample_2x_unit
// [1 2 1]/4 separable blur of a square 8-bit frame with 2x decimation.
//
//   Channel  Direction  Payload                  Handshake
//   req_bus  in         pixel_in[7:0]            valid / ready
//   rsp_bus  out        pixel_out[7:0], last     valid / ready
//   csr_bus  in         side_len[10:0]           valid / ready (always ready)
//
// One pixel is taken every cycle unless a stalled result holds the input; the
// odd-row, odd-column pixel that completes a window yields a registered result.
// The row stores are single-port-write arrays read one pair of columns per
// word; no clearing pass follows reset, and reset leaves a side of four.
// A stalled result only holds words that produce results; others drain.
// Writing the side length restarts the frame at row and column zero.
// ----------------------------------------------------------------------------
module binomial_blur_downsample_2x_unit (
   input  logic          clock,
   input  logic          reset,
   bbd2x_req_if.sink     req_bus,
   bbd2x_rsp_if.source   rsp_bus,
   bbd2x_csr_if.sink     csr_bus
);

   logic                s1_valid;
   logic                s1_take;
   bbd2x_pkg::item_type s1_item;

   bbd2x_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .csr_bus  (csr_bus),
      .s1_valid (s1_valid),
      .s1_item  (s1_item),
      .s1_take  (s1_take)
   );

   bbd2x_vert u_vert (
      .clock    (clock),
      .reset    (reset),
      .s1_valid (s1_valid),
      .s1_item  (s1_item),
      .s1_take  (s1_take),
      .rsp_bus  (rsp_bus)
   );

endmodule
